/* rtl/gdce_pkg.sv */
`timescale 1ns / 1ps
// Package for the GPS-disciplined clock estimator: codes, widths, constants
// and the schedule gate function. No dependencies.
package gdce_pkg;

  localparam int TICK_W  = 48;
  localparam int TIME_W  = 52;
  localparam int HZ_W    = 48;
  localparam int WIN_W   = 40;
  localparam int CNT_W   = 32;
  localparam int REJ_W   = 8;
  localparam int CFG_W   = 48;
  localparam int CIDX_W  = 2;
  localparam int QUO_W   = 48;  // quotient bits below the saturation point
  localparam int STEP_W  = 6;
  localparam int AVG_SHIFT = 5; // exponential moving average, new sample weighted 1/32

  localparam logic [HZ_W-1:0]  INIT_CLOCK_RST = 48'd4369062297600;
  localparam logic [WIN_W-1:0] WIDE_WIN_RST   = 40'd218453115;
  localparam logic [WIN_W-1:0] NARROW_WIN_RST = 40'd4369062;
  localparam logic [REJ_W-1:0] REJECT_LIMIT   = 8'd8;
  localparam logic [CNT_W-1:0] INITIAL_CORR   = 32'd5;
  localparam logic [CNT_W-1:0] HOLDOFF_SEC    = 32'd10;

  localparam logic [2:0] MODE_DISABLED   = 3'd0;
  localparam logic [2:0] MODE_CONTINUOUS = 3'd1;
  localparam logic [2:0] MODE_TWO_MIN    = 3'd2;
  localparam logic [2:0] MODE_FIVE_MIN   = 3'd3;
  localparam logic [2:0] MODE_FIFTEEN    = 3'd4;
  localparam logic [2:0] MODE_THIRTY     = 3'd5;

  localparam logic [2:0] ST_FIRST    = 3'd0;
  localparam logic [2:0] ST_DISABLED = 3'd1;
  localparam logic [2:0] ST_REJECTED = 3'd2;
  localparam logic [2:0] ST_SCHEDULE = 3'd3;
  localparam logic [2:0] ST_APPLIED  = 3'd4;
  localparam logic [2:0] ST_HOLDOFF  = 3'd5;

  localparam logic [CIDX_W-1:0] CFG_MODE    = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_INIT_HZ = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_WIDE    = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_NARROW  = 2'd3;

  typedef struct packed {
    logic capture;
    logic step;
    logic update;
  } cmd_t;

  function automatic logic [5:0] mod5(input logic [5:0] x);
    logic [5:0] v;
    v = x;
    if (v >= 6'd40) v = v - 6'd40;
    if (v >= 6'd20) v = v - 6'd20;
    if (v >= 6'd10) v = v - 6'd10;
    if (v >= 6'd5)  v = v - 6'd5;
    return v;
  endfunction

  function automatic logic [5:0] mod15(input logic [5:0] x);
    logic [5:0] v;
    v = x;
    if (v >= 6'd30) v = v - 6'd30;
    if (v >= 6'd30) v = v - 6'd30;
    if (v >= 6'd15) v = v - 6'd15;
    return v;
  endfunction

  function automatic logic [5:0] mod30(input logic [5:0] x);
    logic [5:0] v;
    v = x;
    if (v >= 6'd30) v = v - 6'd30;
    if (v >= 6'd30) v = v - 6'd30;
    return v;
  endfunction

  function automatic logic gate_open(input logic [2:0] mode, input logic [5:0] min,
                                     input logic [5:0] sec);
    logic ok;
    ok = 1'b0;
    case (mode)
      MODE_TWO_MIN:  ok = min[0] && (sec > 6'd51);
      MODE_FIVE_MIN: ok = (mod5(min) == 6'd4) && (sec > 6'd50);
      MODE_FIFTEEN:  ok = (mod15(min) == 6'd14) && (sec > 6'd50);
      MODE_THIRTY:   ok = (mod30(min) == 6'd29) && (sec > 6'd52);
      default:       ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

/* rtl/gps_disciplined_clock_estimator.sv */
`timescale 1ns / 1ps
// Top level of the GPS-disciplined clock estimator: controller plus datapath.
// Depends on gdce_pkg, gdce_ctrl and gdce_dp.

// Each GPS solution is one input transaction and yields one result. The
// accepting cycle captures the operands, the bit-serial restoring divider
// then forms the measured frequency, and the update writes the state and the
// registered result. The next transaction is taken the cycle after the update,
// even while the result still waits to be read, so a new transaction is taken
// only once the last one is through; a result not yet read holds the following
// one in its update cycle. The first solution after reset is only stored.
// Configuration writes go straight to the registers and must be made while no
// transaction is in flight.
module gps_disciplined_clock_estimator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gdce_pkg::CIDX_W-1:0]     cfg_index,
  input  logic [gdce_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [gdce_pkg::TICK_W-1:0]     tick_count,
  input  logic [gdce_pkg::TIME_W-1:0]     gps_time,
  input  logic [5:0]                      utc_minute,
  input  logic [5:0]                      utc_second,
  input  logic [31:0]                     uptime_seconds,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      status,
  output logic [gdce_pkg::HZ_W-1:0]       clock_estimate_hz,
  output logic [gdce_pkg::HZ_W-1:0]       applied_clock_hz,
  output logic [gdce_pkg::CNT_W-1:0]      correction_count,
  output logic [gdce_pkg::REJ_W-1:0]      reject_run,
  output logic                            correcting
);

  gdce_pkg::cmd_t cmd;

  gdce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  gdce_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .tick_count        (tick_count),
    .gps_time          (gps_time),
    .utc_minute        (utc_minute),
    .utc_second        (utc_second),
    .uptime_seconds    (uptime_seconds),
    .status            (status),
    .clock_estimate_hz (clock_estimate_hz),
    .applied_clock_hz  (applied_clock_hz),
    .correction_count  (correction_count),
    .reject_run        (reject_run),
    .correcting        (correcting)
  );

endmodule

/* rtl/gdce_ctrl.sv */
`timescale 1ns / 1ps
// Controller for the clock estimator: sequences capture, the 48 divide steps
// and the state update, and owns the output valid. Uses gdce_pkg.
module gdce_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output gdce_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DIVIDE = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state, state_next;
  logic [gdce_pkg::STEP_W-1:0] step_cnt;
  logic out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.step    = 1'b0;
    cmd.update  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        cmd.step = 1'b1;
        if (step_cnt == gdce_pkg::STEP_W'(gdce_pkg::QUO_W - 1)) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.update = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.capture) step_cnt <= '0;
      else if (cmd.step) step_cnt <= step_cnt + 1'b1;
      if (cmd.update) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_update_free: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> (!out_valid || out_ready)) else $error("update over pending result");
  a_capture_div: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DIVIDE)) else $error("capture did not start divide");
  a_full_divide: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_FINISH) |-> ($past(step_cnt) == gdce_pkg::STEP_W'(gdce_pkg::QUO_W - 1)))
    else $error("divide ended early");
  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.update)) else $error("result without update");

endmodule

/* rtl/gdce_dp.sv */
`timescale 1ns / 1ps
// Datapath for the clock estimator: config registers, estimator state, the
// restoring divider and the update logic. Uses gdce_pkg.
module gdce_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  gdce_pkg::cmd_t                  cmd,
  input  logic                            cfg_we,
  input  logic [gdce_pkg::CIDX_W-1:0]     cfg_index,
  input  logic [gdce_pkg::CFG_W-1:0]      cfg_data,
  input  logic [gdce_pkg::TICK_W-1:0]     tick_count,
  input  logic [gdce_pkg::TIME_W-1:0]     gps_time,
  input  logic [5:0]                      utc_minute,
  input  logic [5:0]                      utc_second,
  input  logic [31:0]                     uptime_seconds,
  output logic [2:0]                      status,
  output logic [gdce_pkg::HZ_W-1:0]       clock_estimate_hz,
  output logic [gdce_pkg::HZ_W-1:0]       applied_clock_hz,
  output logic [gdce_pkg::CNT_W-1:0]      correction_count,
  output logic [gdce_pkg::REJ_W-1:0]      reject_run,
  output logic                            correcting
);

  localparam int HZ_W  = gdce_pkg::HZ_W;
  localparam int AVG_W = HZ_W + gdce_pkg::AVG_SHIFT + 1;

  logic [2:0]                   mode;
  logic [gdce_pkg::WIN_W-1:0]   wide_win, narrow_win;

  logic [gdce_pkg::TICK_W-1:0]  prev_ticks;
  logic [gdce_pkg::TIME_W-1:0]  prev_time;
  logic                         have_prev;
  logic [HZ_W-1:0]              average_hz;
  logic [31:0]                  last_release;

  // per-transaction captures
  logic                         was_first, pos, sat;
  logic [5:0]                   cap_min, cap_sec;
  logic [31:0]                  cap_now;
  logic [gdce_pkg::TIME_W-1:0]  divisor;
  logic [gdce_pkg::TIME_W-1:0]  rem;
  logic [gdce_pkg::QUO_W-1:0]   quo;
  logic [AVG_W-1:0]             avg31;

  logic [gdce_pkg::TICK_W-1:0]  dticks;
  logic [gdce_pkg::TIME_W-1:0]  dt;
  logic [gdce_pkg::TIME_W:0]    rem2;
  logic                         fits;
  logic [HZ_W-1:0]              freq, freq_err, window, new_avg;
  logic [AVG_W-1:0]             avg_sum;
  logic                         reject, gate_ok, release_ok;

  assign dticks = tick_count - prev_ticks;
  assign dt     = gps_time - prev_time;
  assign rem2   = {rem, 1'b0};
  assign fits   = rem2 >= {1'b0, divisor};

  assign freq   = !pos ? '0 : (sat ? '1 : quo);
  assign window = ((correction_count == '0) || (reject_run > gdce_pkg::REJECT_LIMIT))
                  ? HZ_W'(wide_win) : HZ_W'(narrow_win);
  assign freq_err = (freq >= clock_estimate_hz) ? freq - clock_estimate_hz
                                                : clock_estimate_hz - freq;
  assign reject = !pos || (freq_err > window);
  assign avg_sum = avg31 + AVG_W'(freq) + AVG_W'(1 << (gdce_pkg::AVG_SHIFT - 1));
  // an unseeded average takes the measurement directly
  assign new_avg = (average_hz == '0) ? freq
                 : avg_sum[HZ_W+gdce_pkg::AVG_SHIFT-1:gdce_pkg::AVG_SHIFT];
  assign gate_ok = gdce_pkg::gate_open(mode, cap_min, cap_sec);
  assign release_ok = (cap_now > (last_release + gdce_pkg::HOLDOFF_SEC)) ||
                      (mode > gdce_pkg::MODE_CONTINUOUS);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= gdce_pkg::MODE_CONTINUOUS;
      wide_win          <= gdce_pkg::WIDE_WIN_RST;
      narrow_win        <= gdce_pkg::NARROW_WIN_RST;
      prev_ticks        <= '0;
      prev_time         <= '0;
      have_prev         <= 1'b0;
      average_hz        <= '0;
      clock_estimate_hz <= gdce_pkg::INIT_CLOCK_RST;
      applied_clock_hz  <= gdce_pkg::INIT_CLOCK_RST;
      correction_count  <= '0;
      reject_run        <= '0;
      last_release      <= '0;
      correcting        <= 1'b0;
      status            <= gdce_pkg::ST_FIRST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          gdce_pkg::CFG_MODE:    mode <= cfg_data[2:0];
          gdce_pkg::CFG_INIT_HZ: begin
            // the initial clock only matters before the first correction
            if (correction_count == '0) begin
              clock_estimate_hz <= cfg_data;
              applied_clock_hz  <= cfg_data;
            end
          end
          gdce_pkg::CFG_WIDE:    wide_win   <= cfg_data[gdce_pkg::WIN_W-1:0];
          gdce_pkg::CFG_NARROW:  narrow_win <= cfg_data[gdce_pkg::WIN_W-1:0];
          default: ;
        endcase
      end

      if (cmd.capture) begin
        have_prev <= 1'b1;
        if (!have_prev || (mode != gdce_pkg::MODE_DISABLED)) begin
          prev_ticks <= tick_count;
          prev_time  <= gps_time;
        end
      end

      if (cmd.update) begin
        if (was_first) begin
          status <= gdce_pkg::ST_FIRST;
        end else if (mode == gdce_pkg::MODE_DISABLED) begin
          correcting <= 1'b0;
          status     <= gdce_pkg::ST_DISABLED;
        end else if (reject) begin
          if (reject_run != '1) reject_run <= reject_run + 1'b1;
          status <= gdce_pkg::ST_REJECTED;
        end else begin
          reject_run        <= '0;
          average_hz        <= new_avg;
          clock_estimate_hz <= new_avg;
          if (correction_count != '1) correction_count <= correction_count + 1'b1;
          if ((mode > gdce_pkg::MODE_CONTINUOUS) &&
              (correction_count > gdce_pkg::INITIAL_CORR) && !gate_ok) begin
            correcting <= 1'b0;
            status     <= gdce_pkg::ST_SCHEDULE;
          end else begin
            correcting <= 1'b1;
            if (release_ok) begin
              applied_clock_hz <= new_avg;
              last_release     <= cap_now;
              status           <= gdce_pkg::ST_APPLIED;
            end else begin
              status <= gdce_pkg::ST_HOLDOFF;
            end
          end
        end
      end
    end
  end

  // transaction captures and divider; no reset needed
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      was_first <= !have_prev;
      pos       <= gps_time > prev_time;
      sat       <= {4'd0, dticks} >= dt;
      divisor   <= dt;
      rem       <= {4'd0, dticks};
      quo       <= '0;
      cap_min   <= utc_minute;
      cap_sec   <= utc_second;
      cap_now   <= uptime_seconds;
      avg31     <= (AVG_W'(average_hz) << gdce_pkg::AVG_SHIFT) - AVG_W'(average_hz);
    end else if (cmd.step) begin
      rem <= fits ? rem2[gdce_pkg::TIME_W-1:0] - divisor : rem2[gdce_pkg::TIME_W-1:0];
      quo <= {quo[gdce_pkg::QUO_W-2:0], fits};
    end
  end

endmodule
